@@ src/two_rate_wavetable_sample_generator_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the two-rate wavetable sample generator
// Same-cycle and next-cycle implication checks, removable as a group.
// ----------------------------------------------------------------------------
`ifndef TWO_RATE_WAVETABLE_SAMPLE_GENERATOR_CORE_DEFINES_SVH
`define TWO_RATE_WAVETABLE_SAMPLE_GENERATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define TWG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("twg check failed");
// antecedent implies consequent in the next cycle
`define TWG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("twg check failed");
`else
`define TWG_ASSERT_SAME(label, clk, rst, ante, cons)
`define TWG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/twg_pkg.sv @@
// ----------------------------------------------------------------------------
// twg_pkg
// Shared types, constants and the sine table for the sample generator.
// ----------------------------------------------------------------------------
package twg_pkg;

   localparam int unsigned ROM_ADDR_W  = 8;
   localparam int unsigned ROM_DEPTH   = 256;
   localparam int unsigned SAMPLE_W    = 8;
   localparam int unsigned DAC_W       = 12;
   localparam int unsigned DAC_SHIFT   = 4;
   localparam int unsigned PRODUCT_W   = 23;
   localparam int unsigned SCALED_W    = 38;

   localparam logic [6:0] RATIO_NONE = 7'd0;
   localparam logic [6:0] RATIO_FULL = 7'd100;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

   // csr register indexes
   localparam logic [1:0] REG_BIAS      = 2'd0;
   localparam logic [1:0] REG_TWO_TONE  = 2'd1;
   localparam logic [1:0] REG_RATIO     = 2'd2;
   localparam logic [1:0] REG_PERIOD    = 2'd3;

   localparam logic signed [8:0] BIAS_RESET   = 9'sd0;
   localparam logic [6:0]        RATIO_RESET  = 7'd50;
   localparam logic [15:0]       PERIOD_RESET = 16'd1000;

   typedef struct packed {
      logic signed [8:0] bias;
      logic              two_tone_enable;
      logic [6:0]        ratio_percent;
      logic [15:0]       period_ms;
   } twg_cfg_type;

   // first quarter plus peak of the sine table
   localparam logic [7:0] QUARTER_ROM [0:64] = '{
      8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
      8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185,
      8'd188, 8'd190, 8'd193, 8'd196, 8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211,
      8'd213, 8'd215, 8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
      8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244, 8'd245, 8'd246,
      8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254,
      8'd254, 8'd255, 8'd255, 8'd255, 8'd255
   };

   // full-wave read built from the quarter table by symmetry
   function automatic logic [SAMPLE_W-1:0] rom_read(input logic [ROM_ADDR_W-1:0] addr);
      logic [6:0] pos;
      logic [6:0] mirror;
      logic [7:0] diff;
      logic [SAMPLE_W-1:0] value;
      pos  = addr[6:0];
      diff = 8'd128 - {1'b0, pos};
      if (pos <= 7'd64) begin
         mirror = pos;
      end else begin
         mirror = diff[6:0];
      end
      value = QUARTER_ROM[mirror];
      if (addr[7] && (pos != 7'd0)) begin
         value = SAMPLE_MAX - value;
      end
      return value;
   endfunction

endpackage

@@ src/twg_csr.sv @@
// ----------------------------------------------------------------------------
// twg_csr
// Configuration registers behind the register bus port.
// ----------------------------------------------------------------------------
module twg_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output twg_pkg::twg_cfg_type cfg
);
   import twg_pkg::*;

   twg_cfg_type cfg_ff;
   twg_cfg_type cfg_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_BIAS:     cfg_in.bias            = $signed(csr_pwdata[8:0]);
            REG_TWO_TONE: cfg_in.two_tone_enable = csr_pwdata[0];
            REG_RATIO:    cfg_in.ratio_percent   = csr_pwdata[6:0];
            REG_PERIOD:   cfg_in.period_ms       = csr_pwdata[15:0];
            default:      cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_BIAS:     csr_prdata = {23'd0, cfg_ff.bias};
         REG_TWO_TONE: csr_prdata = {31'd0, cfg_ff.two_tone_enable};
         REG_RATIO:    csr_prdata = {25'd0, cfg_ff.ratio_percent};
         REG_PERIOD:   csr_prdata = {16'd0, cfg_ff.period_ms};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bias            <= BIAS_RESET;
         cfg_ff.two_tone_enable <= 1'b0;
         cfg_ff.ratio_percent   <= RATIO_RESET;
         cfg_ff.period_ms       <= PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/twg_sample.sv @@
// ----------------------------------------------------------------------------
// twg_sample
// Phase counter, sine table read, bias add and saturation to a DAC code.
// ----------------------------------------------------------------------------
module twg_sample #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic signed [8:0] bias,
   output logic [11:0]       dac_code
);
   import twg_pkg::*;

   localparam int unsigned PHASE_W   = $clog2(TABLE_DEPTH);
   localparam int unsigned REM_W     = $clog2(TABLE_DEPTH);
   localparam int unsigned ADDR_STEP = ROM_DEPTH / TABLE_DEPTH;
   localparam int unsigned REM_STEP  = ROM_DEPTH % TABLE_DEPTH;

   // addr_ff and rem_ff track phase*256 = addr*TABLE_DEPTH + rem
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [ROM_ADDR_W-1:0] addr_ff, addr_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [REM_W:0]        rem_sum;
   logic                  rem_carry;
   logic [SAMPLE_W-1:0]   rom_val;
   logic signed [9:0]     biased;
   logic [SAMPLE_W-1:0]   sat;

   assign rem_sum   = {1'b0, rem_ff} + (REM_W+1)'(REM_STEP);
   assign rem_carry = rem_sum >= (REM_W+1)'(TABLE_DEPTH);

   always_comb begin
      if (phase_ff == PHASE_W'(TABLE_DEPTH - 1)) begin
         phase_in = '0;
         addr_in  = '0;
         rem_in   = '0;
      end else begin
         phase_in = phase_ff + PHASE_W'(1);
         addr_in  = addr_ff + ROM_ADDR_W'(ADDR_STEP) + ROM_ADDR_W'(rem_carry);
         if (rem_carry) begin
            rem_in = REM_W'(rem_sum - (REM_W+1)'(TABLE_DEPTH));
         end else begin
            rem_in = rem_sum[REM_W-1:0];
         end
      end
   end

   assign rom_val = rom_read(addr_ff);
   assign biased  = $signed({2'b00, rom_val}) + $signed({bias[8], bias});

   always_comb begin
      if (biased < 0) begin
         sat = '0;
      end else if (biased > $signed({2'b00, SAMPLE_MAX})) begin
         sat = SAMPLE_MAX;
      end else begin
         sat = biased[SAMPLE_W-1:0];
      end
   end

   assign dac_code = {sat, DAC_SHIFT'(0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         addr_ff  <= '0;
         rem_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

@@ src/twg_rate.sv @@
// ----------------------------------------------------------------------------
// twg_rate
// Elapsed-time tracking and high/low rate switching for two-tone mode.
// ----------------------------------------------------------------------------
module twg_rate (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [31:0]          now_ms,
   input  twg_pkg::twg_cfg_type cfg,
   output logic                 rate_low,
   output logic                 rate_next
);
   import twg_pkg::*;

   logic                 low_ff, low_in;
   logic                 armed_ff, armed_in;
   logic                 captured_ff;
   logic [31:0]          start_ff, start_in;
   logic [PRODUCT_W-1:0] product_ff;
   logic [31:0]          elapsed;
   logic [SCALED_W-1:0]  elapsed_x50;
   logic                 past_low_mark;
   logic                 past_full_mark;

   // first tick sees zero elapsed time
   assign elapsed = captured_ff ? (now_ms - start_ff) : 32'd0;

   // elapsed >= floor(P/50) is the same as 50*elapsed + 49 >= P
   assign elapsed_x50 = ({6'd0, elapsed} << 5) + ({6'd0, elapsed} << 4)
                      + ({6'd0, elapsed} << 1) + SCALED_W'(49);
   assign past_low_mark  = elapsed_x50 >= {15'd0, product_ff};
   assign past_full_mark = elapsed >= {15'd0, cfg.period_ms, 1'b0};

   always_comb begin
      low_in   = low_ff;
      armed_in = armed_ff;
      start_in = captured_ff ? start_ff : now_ms;
      if (cfg.two_tone_enable) begin
         if (low_ff) begin
            if ((cfg.ratio_percent != RATIO_NONE) && past_full_mark) begin
               armed_in = 1'b1;
               low_in   = 1'b0;
               start_in = now_ms;
            end
         end else if ((cfg.ratio_percent != RATIO_FULL) && armed_ff) begin
            if (past_low_mark) begin
               armed_in = 1'b0;
               low_in   = 1'b1;
            end
         end
      end
   end

   assign rate_low  = low_ff;
   assign rate_next = low_in;

   always_ff @(posedge clock) begin
      product_ff <= cfg.period_ms * cfg.ratio_percent;
      if (reset) begin
         low_ff      <= 1'b0;
         armed_ff    <= 1'b1;
         captured_ff <= 1'b0;
         start_ff    <= '0;
      end else if (step) begin
         low_ff      <= low_in;
         armed_ff    <= armed_in;
         captured_ff <= 1'b1;
         start_ff    <= start_in;
      end
   end

endmodule

@@ src/two_rate_wavetable_sample_generator_core.sv @@
// ----------------------------------------------------------------------------
// An input transfer reaches the rsp side via the input and result registers.
// Throughput: one tick per cycle, sustained while the result side keeps up.
// Config writes reach the threshold product via the config and product registers.
// Reset: synchronous, active high; clears phase, rate state, start capture and
// the pipeline, and loads register defaults.
// ----------------------------------------------------------------------------
// two_rate_wavetable_sample_generator_core
// Top level: input register, sample and rate logic, result register.
// ----------------------------------------------------------------------------
`include "two_rate_wavetable_sample_generator_core_defines.svh"

module two_rate_wavetable_sample_generator_core #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // input ticks
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] now_ms
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] dac_code, [15:12] zero
   output logic        rsp_tuser,   // [0] rate_select
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import twg_pkg::*;

   twg_cfg_type       cfg;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [31:0]       s1_now_ff;
   // result register
   logic              out_valid_ff, out_valid_in;
   logic [DAC_W-1:0]  out_dac_ff;
   logic              out_rate_ff;

   logic              advance;
   logic              step;
   logic              req_xfer;
   logic [DAC_W-1:0]  dac_code;
   logic              rate_low;
   logic              rate_next;

   // advance the result register whenever it is empty or being taken
   assign advance    = !out_valid_ff || rsp_tready;
   // the held tick moves into the result register: commit its state changes
   assign step       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   twg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   twg_sample #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_sample (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .bias     (cfg.bias),
      .dac_code (dac_code)
   );

   twg_rate u_rate (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .now_ms    (s1_now_ff),
      .cfg       (cfg),
      .rate_low  (rate_low),
      .rate_next (rate_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      // payload: hold unless a transfer lands
      if (req_xfer) begin
         s1_now_ff <= req_tdata;
      end
      if (step) begin
         out_dac_ff  <= dac_code;
         out_rate_ff <= rate_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_dac_ff};
   assign rsp_tuser  = out_rate_ff;

   // the low nibble of the DAC code is always clear
   `TWG_ASSERT_SAME(a_dac_nibble, clock, reset, rsp_tvalid, rsp_tdata[3:0] == 4'd0)
   // an empty input stage always takes a transfer
   `TWG_ASSERT_SAME(a_ready_empty, clock, reset, !s1_valid_ff, req_tready)
   // rate state moves only when a tick is committed
   `TWG_ASSERT_NEXT(a_rate_hold, clock, reset, !step, $stable(rate_low))

endmodule
